@@ src/sdsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sdsc_pkg;

    localparam int CW         = 16;
    localparam int RADW       = 15;
    localparam int DW         = 16;
    localparam int VW         = CW + 1;
    localparam int AW         = 2 * VW;
    localparam int BW         = 2 * VW + 2;
    localparam int MW         = 30;
    localparam int ACCW       = 2 * MW;
    localparam int GUARD      = 8;
    localparam int SCALE_SH   = 2 * GUARD;
    localparam int NW         = 54;
    localparam int REMW       = 30;
    localparam int LW         = 25;
    localparam int PW         = 28;
    localparam int QW         = 27;
    localparam int SW         = 29;
    localparam int SQRT_STEPS = NW / 2;
    localparam int DIV_STEPS  = NW;
    localparam int CNTW       = 6;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic [RADW-1:0]      robot_radius;
        logic [DW-1:0]        max_distance;
    } cfg_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_A0,
        CMD_A1,
        CMD_B0,
        CMD_B1,
        CMD_D0,
        CMD_D1,
        CMD_SQA,
        CMD_LEN,
        CMD_DVP,
        CMD_PSET,
        CMD_R0,
        CMD_R1,
        CMD_R2,
        CMD_SQQ,
        CMD_QSET,
        CMD_SSEL,
        CMD_X0,
        CMD_DX,
        CMD_XSET,
        CMD_Y0,
        CMD_DY,
        CMD_YSET,
        CMD_UPD,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic a_zero;
        logic q2_neg;
        logic take;
        logic iter_busy;
    } dp_status_t;

    typedef struct packed {
        logic start_sqrt;
        logic start_div;
    } iter_ctl_t;

endpackage

`default_nettype wire

@@ src/sdsc_iter.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdsc_iter import sdsc_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  iter_ctl_t     ctl,
    input  logic [NW-1:0] num,
    input  logic [LW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] res
);

    logic [NW-1:0]   work_reg;
    logic [NW-1:0]   res_reg;
    logic [REMW-1:0] rem_reg;
    logic [LW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            sqrt_reg;
    logic            busy_reg;

    logic [REMW-1:0] sq_rem;
    logic [REMW-1:0] sq_trial;
    logic [REMW-1:0] dv_rem;
    logic [REMW-1:0] dv_den;
    logic            step_ge;
    logic [REMW-1:0] rem_next;
    logic [NW-1:0]   work_next;

    always_comb begin
        sq_rem   = {rem_reg[REMW-3:0], work_reg[NW-1 -: 2]};
        sq_trial = {res_reg[REMW-3:0], 2'b01};
        dv_rem   = {rem_reg[REMW-2:0], work_reg[NW-1]};
        dv_den   = REMW'(den_reg);
        if (sqrt_reg) begin
            step_ge   = sq_rem >= sq_trial;
            rem_next  = step_ge ? sq_rem - sq_trial : sq_rem;
            work_next = {work_reg[NW-3:0], 2'b00};
        end else begin
            step_ge   = dv_rem >= dv_den;
            rem_next  = step_ge ? dv_rem - dv_den : dv_rem;
            work_next = {work_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (ctl.start_sqrt || ctl.start_div) begin
            work_reg <= num;
            den_reg  <= den;
            res_reg  <= '0;
            rem_reg  <= '0;
            sqrt_reg <= ctl.start_sqrt;
            cnt_reg  <= ctl.start_sqrt ? CNTW'(SQRT_STEPS - 1) : CNTW'(DIV_STEPS - 1);
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            res_reg  <= {res_reg[NW-2:0], step_ge};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

@@ src/sdsc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdsc_datapath import sdsc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 clear_scan,
    input  logic [DW-1:0]        clear_value,
    input  logic                 load,
    input  logic signed [CW-1:0] obstacle_x,
    input  logic signed [CW-1:0] obstacle_y,
    input  cmd_t                 cmd,
    output dp_status_t           status,
    output logic                 hit,
    output logic [DW-1:0]        min_distance,
    output logic signed [CW-1:0] point_x,
    output logic signed [CW-1:0] point_y
);

    logic signed [VW-1:0]   vx_reg, vy_reg, dx_reg, dy_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic [AW-1:0]          a_reg;
    logic signed [BW-1:0]   bh_reg;
    logic [AW-1:0]          d2_reg;
    logic [LW-1:0]          len_reg;
    logic signed [PW-1:0]   p_reg;
    logic signed [NW-1:0]   q2_reg;
    logic [QW-1:0]          q_reg;
    logic [LW-1:0]          s_reg;
    logic [DW-1:0]          dist_reg;
    logic                   take_reg;
    logic                   neg_reg;
    logic signed [CW-1:0]   px_reg, py_reg;
    logic [DW-1:0]          best_dist_reg;
    logic signed [CW-1:0]   best_x_reg, best_y_reg;
    logic                   out_hit_reg;
    logic [DW-1:0]          out_dist_reg;
    logic signed [CW-1:0]   out_x_reg, out_y_reg;

    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [ACCW-1:0] prod;
    logic signed [ACCW-1:0] acc_sum;
    logic signed [BW-1:0]   bh_abs;
    logic signed [ACCW-1:0] acc_abs;
    logic [NW-1:0]          half_len;
    logic [NW-1:0]          iter_num;
    iter_ctl_t              iter_ctl;
    logic                   iter_busy;
    logic [NW-1:0]          iter_res;
    logic signed [PW-1:0]   quo, quo_s;
    logic signed [SW-1:0]   p_ext, q_ext, len_ext, s0, s1, s_sel;
    logic                   in0, in1;
    logic [LW:0]            dist_sum;
    logic [DW-1:0]          dist_new;
    logic                   hit_now;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            CMD_A0: begin mul_a = MW'(vx_reg); mul_b = MW'(vx_reg); end
            CMD_A1: begin mul_a = MW'(vy_reg); mul_b = MW'(vy_reg); end
            CMD_B0: begin mul_a = MW'(vx_reg); mul_b = MW'(dx_reg); end
            CMD_B1: begin mul_a = MW'(vy_reg); mul_b = MW'(dy_reg); end
            CMD_D0: begin mul_a = MW'(dx_reg); mul_b = MW'(dx_reg); end
            CMD_D1: begin mul_a = MW'(dy_reg); mul_b = MW'(dy_reg); end
            CMD_R0: begin
                mul_a = $signed(MW'(cfg.robot_radius));
                mul_b = $signed(MW'(cfg.robot_radius));
            end
            CMD_R2: begin mul_a = MW'(p_reg); mul_b = MW'(p_reg); end
            CMD_X0: begin mul_a = MW'(vx_reg); mul_b = $signed(MW'(s_reg)); end
            CMD_Y0: begin mul_a = MW'(vy_reg); mul_b = $signed(MW'(s_reg)); end
            default: ;
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign acc_sum = acc_reg + prod;
    assign bh_abs  = bh_reg[BW-1] ? -bh_reg : bh_reg;
    assign acc_abs = acc_reg[ACCW-1] ? -acc_reg : acc_reg;
    assign half_len = NW'(len_reg >> 1);

    always_comb begin
        case (cmd)
            CMD_SQA: iter_num = NW'({a_reg, {SCALE_SH{1'b0}}});
            CMD_SQQ: iter_num = q2_reg;
            CMD_DVP: iter_num = NW'({bh_abs[BW-2:0], {SCALE_SH{1'b0}}}) + half_len;
            CMD_DX,
            CMD_DY:  iter_num = acc_abs[NW-1:0] + half_len;
            default: iter_num = '0;
        endcase
        iter_ctl.start_sqrt = (cmd == CMD_SQA) || (cmd == CMD_SQQ);
        iter_ctl.start_div  = (cmd == CMD_DVP) || (cmd == CMD_DX) || (cmd == CMD_DY);
    end

    sdsc_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (iter_ctl),
        .num     (iter_num),
        .den     (len_reg),
        .busy    (iter_busy),
        .res     (iter_res)
    );

    assign quo   = $signed(iter_res[PW-1:0]);
    assign quo_s = neg_reg ? -quo : quo;

    always_comb begin
        p_ext    = SW'(p_reg);
        q_ext    = $signed(SW'(q_reg));
        len_ext  = $signed(SW'(len_reg));
        s0       = p_ext - q_ext;
        s1       = p_ext + q_ext;
        in0      = !s0[SW-1] && (s0 <= len_ext);
        in1      = !s1[SW-1] && (s1 <= len_ext);
        s_sel    = in0 ? s0 : s1;
        dist_sum = {1'b0, s_sel[LW-1:0]} + (LW+1)'(1 << (GUARD - 1));
        dist_new = (dist_sum[LW:GUARD+DW] != '0) ? '1 : dist_sum[GUARD+DW-1:GUARD];
    end

    assign hit_now = best_dist_reg != cfg.max_distance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_dist_reg <= '1;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
        end else if (clear_scan) begin
            best_dist_reg <= clear_value;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
        end else if (cmd == CMD_UPD) begin
            best_dist_reg <= dist_reg;
            best_x_reg    <= px_reg;
            best_y_reg    <= py_reg;
        end else if (cmd == CMD_EMIT) begin
            best_dist_reg <= cfg.max_distance;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            vx_reg <= VW'(cfg.end_x) - VW'(cfg.start_x);
            vy_reg <= VW'(cfg.end_y) - VW'(cfg.start_y);
            dx_reg <= VW'(cfg.start_x) - VW'(obstacle_x);
            dy_reg <= VW'(cfg.start_y) - VW'(obstacle_y);
        end
        case (cmd)
            CMD_A0, CMD_B0, CMD_D0, CMD_R0, CMD_X0, CMD_Y0: acc_reg <= prod;
            CMD_A1: a_reg  <= acc_sum[AW-1:0];
            CMD_B1: bh_reg <= acc_sum[BW-1:0];
            CMD_D1: d2_reg <= acc_sum[AW-1:0];
            CMD_LEN: len_reg <= iter_res[LW-1:0];
            CMD_DVP: neg_reg <= !bh_reg[BW-1];
            CMD_DX, CMD_DY: neg_reg <= acc_reg[ACCW-1];
            CMD_PSET: p_reg <= quo_s;
            CMD_R1: acc_reg <= (acc_reg - $signed(ACCW'(d2_reg))) <<< SCALE_SH;
            CMD_R2: q2_reg <= acc_sum[NW-1:0];
            CMD_QSET: q_reg <= iter_res[QW-1:0];
            CMD_SSEL: begin
                s_reg    <= s_sel[LW-1:0];
                dist_reg <= dist_new;
                take_reg <= (in0 || in1) && (dist_new < best_dist_reg);
            end
            CMD_XSET: px_reg <= cfg.start_x + quo_s[CW-1:0];
            CMD_YSET: py_reg <= cfg.start_y + quo_s[CW-1:0];
            CMD_EMIT: begin
                out_hit_reg  <= hit_now;
                out_dist_reg <= best_dist_reg;
                out_x_reg    <= hit_now ? best_x_reg : '0;
                out_y_reg    <= hit_now ? best_y_reg : '0;
            end
            default: ;
        endcase
    end

    assign status.a_zero    = a_reg == '0;
    assign status.q2_neg    = q2_reg[NW-1];
    assign status.take      = take_reg;
    assign status.iter_busy = iter_busy;

    assign hit          = out_hit_reg;
    assign min_distance = out_dist_reg;
    assign point_x      = out_x_reg;
    assign point_y      = out_y_reg;

endmodule

`default_nettype wire

@@ src/sdsc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdsc_ctrl import sdsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tlast,
    input  logic       m_tready,
    input  dp_status_t status,
    output logic       s_tready,
    output logic       m_tvalid,
    output logic       load,
    output cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_A0, ST_A1, ST_B0, ST_B1, ST_D0, ST_D1,
        ST_SQA, ST_SQA_W, ST_LEN, ST_DVP, ST_DVP_W, ST_PSET,
        ST_R0, ST_R1, ST_R2, ST_SQQ, ST_SQQ_W, ST_QSET, ST_SSEL,
        ST_X0, ST_DX, ST_DX_W, ST_XSET, ST_Y0, ST_DY, ST_DY_W,
        ST_YSET, ST_UPD, ST_FIN, ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = state_reg == ST_IDLE;
    assign load     = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cmd           = CMD_NONE;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:  if (load) state_next = ST_A0;
            ST_A0:    begin cmd = CMD_A0; state_next = ST_A1; end
            ST_A1:    begin cmd = CMD_A1; state_next = ST_B0; end
            ST_B0: begin
                if (status.a_zero) begin
                    state_next = ST_FIN;
                end else begin
                    cmd = CMD_B0;
                    state_next = ST_B1;
                end
            end
            ST_B1:    begin cmd = CMD_B1; state_next = ST_D0; end
            ST_D0:    begin cmd = CMD_D0; state_next = ST_D1; end
            ST_D1:    begin cmd = CMD_D1; state_next = ST_SQA; end
            ST_SQA:   begin cmd = CMD_SQA; state_next = ST_SQA_W; end
            ST_SQA_W: if (!status.iter_busy) state_next = ST_LEN;
            ST_LEN:   begin cmd = CMD_LEN; state_next = ST_DVP; end
            ST_DVP:   begin cmd = CMD_DVP; state_next = ST_DVP_W; end
            ST_DVP_W: if (!status.iter_busy) state_next = ST_PSET;
            ST_PSET:  begin cmd = CMD_PSET; state_next = ST_R0; end
            ST_R0:    begin cmd = CMD_R0; state_next = ST_R1; end
            ST_R1:    begin cmd = CMD_R1; state_next = ST_R2; end
            ST_R2:    begin cmd = CMD_R2; state_next = ST_SQQ; end
            ST_SQQ: begin
                if (status.q2_neg) begin
                    state_next = ST_FIN;
                end else begin
                    cmd = CMD_SQQ;
                    state_next = ST_SQQ_W;
                end
            end
            ST_SQQ_W: if (!status.iter_busy) state_next = ST_QSET;
            ST_QSET:  begin cmd = CMD_QSET; state_next = ST_SSEL; end
            ST_SSEL:  begin cmd = CMD_SSEL; state_next = ST_X0; end
            ST_X0: begin
                if (!status.take) begin
                    state_next = ST_FIN;
                end else begin
                    cmd = CMD_X0;
                    state_next = ST_DX;
                end
            end
            ST_DX:    begin cmd = CMD_DX; state_next = ST_DX_W; end
            ST_DX_W:  if (!status.iter_busy) state_next = ST_XSET;
            ST_XSET:  begin cmd = CMD_XSET; state_next = ST_Y0; end
            ST_Y0:    begin cmd = CMD_Y0; state_next = ST_DY; end
            ST_DY:    begin cmd = CMD_DY; state_next = ST_DY_W; end
            ST_DY_W:  if (!status.iter_busy) state_next = ST_YSET;
            ST_YSET:  begin cmd = CMD_YSET; state_next = ST_UPD; end
            ST_UPD:   begin cmd = CMD_UPD; state_next = ST_FIN; end
            ST_FIN:   state_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (out_free) begin
                    cmd = CMD_EMIT;
                    m_tvalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            last_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (load) begin
                last_reg <= s_tlast;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

@@ src/swept_disc_segment_clearance.sv @@
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tdata = obstacle_x, obstacle_y; s_tlast = last_point
// m_        out  m_tvalid / m_tready    m_tdata = min_distance, point_x, point_y; m_tuser = hit
// apb       in   psel, penable, pready  paddr = 4 * register index, pwdata, prdata
//
// one item at a time; an item ends early for a zero-length path, when there is no real
// root, or when the contact is off the path or not closer; a new closest hit runs the
// whole sequence, and the last item of a scan also emits the result
// square roots and divisions share one bit-serial unit: 27 steps per square root, 54 per
// division, each followed by a state that takes the result
// reset is synchronous active low and loads the register defaults and an empty scan
// a finished result waits in the output register while the next item is taken; the next
// result stalls until that one is accepted
`timescale 1ns / 1ps
`default_nettype none

module swept_disc_segment_clearance import sdsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // obstacle_x, obstacle_y
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // min_distance, point_x, point_y
    output logic        m_tuser,   // hit
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] REG_START_X      = 3'd0;
    localparam logic [2:0] REG_START_Y      = 3'd1;
    localparam logic [2:0] REG_END_X        = 3'd2;
    localparam logic [2:0] REG_END_Y        = 3'd3;
    localparam logic [2:0] REG_ROBOT_RADIUS = 3'd4;
    localparam logic [2:0] REG_MAX_DISTANCE = 3'd5;

    cfg_t                 cfg_reg;
    logic [2:0]           reg_idx;
    logic                 cfg_wr;
    logic                 clear_scan;
    cmd_t                 cmd;
    dp_status_t           status;
    logic                 load;
    logic                 hit;
    logic [DW-1:0]        min_distance;
    logic signed [CW-1:0] point_x, point_y;

    assign pready     = 1'b1;
    assign reg_idx    = paddr[4:2];
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign clear_scan = cfg_wr && (reg_idx == REG_MAX_DISTANCE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x      <= '0;
            cfg_reg.start_y      <= '0;
            cfg_reg.end_x        <= '0;
            cfg_reg.end_y        <= '0;
            cfg_reg.robot_radius <= '0;
            cfg_reg.max_distance <= '1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_START_X:      cfg_reg.start_x      <= pwdata[CW-1:0];
                REG_START_Y:      cfg_reg.start_y      <= pwdata[CW-1:0];
                REG_END_X:        cfg_reg.end_x        <= pwdata[CW-1:0];
                REG_END_Y:        cfg_reg.end_y        <= pwdata[CW-1:0];
                REG_ROBOT_RADIUS: cfg_reg.robot_radius <= pwdata[RADW-1:0];
                REG_MAX_DISTANCE: cfg_reg.max_distance <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_X:      prdata = 32'(cfg_reg.start_x[CW-1:0]);
            REG_START_Y:      prdata = 32'(cfg_reg.start_y[CW-1:0]);
            REG_END_X:        prdata = 32'(cfg_reg.end_x[CW-1:0]);
            REG_END_Y:        prdata = 32'(cfg_reg.end_y[CW-1:0]);
            REG_ROBOT_RADIUS: prdata = 32'(cfg_reg.robot_radius);
            REG_MAX_DISTANCE: prdata = 32'(cfg_reg.max_distance);
            default:          prdata = '0;
        endcase
    end

    sdsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .load     (load),
        .cmd      (cmd)
    );

    sdsc_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .clear_scan   (clear_scan),
        .clear_value  (pwdata[DW-1:0]),
        .load         (load),
        .obstacle_x   ($signed(s_tdata[CW-1:0])),
        .obstacle_y   ($signed(s_tdata[2*CW-1:CW])),
        .cmd          (cmd),
        .status       (status),
        .hit          (hit),
        .min_distance (min_distance),
        .point_x      (point_x),
        .point_y      (point_y)
    );

    assign m_tdata = {point_y, point_x, min_distance};
    assign m_tuser = hit;

endmodule

`default_nettype wire

@@ src/sdsc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[47:16] == 32'd0)
        else $error("collision point not zero without hit");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while previous item in work");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

endmodule

bind swept_disc_segment_clearance sdsc_checker u_sdsc_checker (.*);

`default_nettype wire

@@ verif/tb_swept_disc_segment_clearance.sv @@
`timescale 1ns / 1ps

module tb_swept_disc_segment_clearance;
    import sdsc_pkg::*;

    localparam int REG_START_X  = 0;
    localparam int REG_START_Y  = 1;
    localparam int REG_END_X    = 2;
    localparam int REG_END_Y    = 3;
    localparam int REG_RADIUS   = 4;
    localparam int REG_MAX_DIST = 5;
    localparam int SETTLE       = 300;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic          hit;
        logic [DW-1:0] min_dist;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
    } clearance_t;

    class clearance_scoreboard;
        longint    sx, sy, ex, ey, radius;
        longint    max_dist, best_dist, best_x, best_y;
        clearance_t scan_q[$];
        int        errors;

        function new();
            sx = 0; sy = 0; ex = 0; ey = 0; radius = 0;
            max_dist = 65535; errors = 0;
            restart_scan();
        endfunction

        function void restart_scan();
            best_dist = max_dist;
            best_x = 0;
            best_y = 0;
        endfunction

        function longint root_floor(longint unsigned n);
            longint unsigned res, bit_v;
            res = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > n) bit_v = bit_v >> 2;
            while (bit_v != 0) begin
                if (n >= res + bit_v) begin
                    n = n - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
            return longint'(res);
        endfunction

        function longint div_nearest(longint num, longint den);
            longint m, q;
            m = num < 0 ? -num : num;
            q = (m + den / 2) / den;
            return num < 0 ? -q : q;
        endfunction

        function void write_reg(int idx, logic [31:0] v);
            case (idx)
                REG_START_X:  sx = longint'($signed(v[15:0]));
                REG_START_Y:  sy = longint'($signed(v[15:0]));
                REG_END_X:    ex = longint'($signed(v[15:0]));
                REG_END_Y:    ey = longint'($signed(v[15:0]));
                REG_RADIUS:   radius = longint'(v[14:0]);
                REG_MAX_DIST: begin
                    max_dist = longint'(v[15:0]);
                    restart_scan();
                end
                default: ;
            endcase
        endfunction

        function void sweep_point(longint ox, longint oy);
            longint vx, vy, dx, dy, a, bh, d2, len, p, q2, q, s0, s1, s, travel;
            vx = ex - sx; vy = ey - sy;
            dx = sx - ox; dy = sy - oy;
            a = vx * vx + vy * vy;
            if (a == 0) return;
            bh = vx * dx + vy * dy;
            d2 = dx * dx + dy * dy;
            len = root_floor(a << 16);
            if (len == 0) return;
            p = div_nearest(-bh << 16, len);
            q2 = ((radius * radius) << 16) - (d2 << 16) + p * p;
            if (q2 < 0) return;
            q = root_floor(q2);
            s0 = p - q;
            s1 = p + q;
            if (s0 >= 0 && s0 <= len) s = s0;
            else if (s1 >= 0 && s1 <= len) s = s1;
            else return;
            travel = (s + 128) >>> 8;
            if (travel > 65535) travel = 65535;
            if (travel < best_dist) begin
                best_dist = travel;
                best_x = sx + div_nearest(vx * s, len);
                best_y = sy + div_nearest(vy * s, len);
            end
        endfunction

        function void note_item(logic [15:0] ox, logic [15:0] oy, logic last);
            clearance_t r;
            sweep_point(longint'($signed(ox)), longint'($signed(oy)));
            if (last) begin
                r.hit      = best_dist != max_dist;
                r.min_dist = best_dist[15:0];
                r.px       = r.hit ? best_x[15:0] : '0;
                r.py       = r.hit ? best_y[15:0] : '0;
                scan_q.push_back(r);
                restart_scan();
            end
        endfunction

        function void check_result(logic hit, logic [47:0] data);
            clearance_t e;
            if (scan_q.size() == 0) begin
                $display("%0t unexpected result hit=%0d data=%h", $time, hit, data);
                errors++;
                return;
            end
            e = scan_q.pop_front();
            if (hit !== e.hit) begin
                $display("%0t hit: expected %0d actual %0d", $time, e.hit, hit);
                errors++;
            end
            if (data[15:0] !== e.min_dist) begin
                $display("%0t min_distance: expected %h actual %h", $time, e.min_dist,
                         data[15:0]);
                errors++;
            end
            if (data[31:16] !== e.px) begin
                $display("%0t point_x: expected %h actual %h", $time, e.px, data[31:16]);
                errors++;
            end
            if (data[47:32] !== e.py) begin
                $display("%0t point_y: expected %h actual %h", $time, e.py, data[47:32]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, s_tlast;
    logic [31:0] s_tdata;
    logic        m_tvalid, m_tready, m_tuser;
    logic [47:0] m_tdata;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    clearance_scoreboard sb;
    int  stall_cycles;
    bit  running;

    swept_disc_segment_clearance u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int gap;
        m_tready = 1'b0;
        wait (running);
        forever begin
            @(negedge aclk);
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            sb.check_result(m_tuser, m_tdata);
        end
    end

    task automatic send_point(logic [15:0] ox, logic [15:0] oy, logic last, bit busy = 0);
        int gap;
        gap = busy ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {oy, ox};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(ox, oy, last);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.scan_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic reg_write(int idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, v);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_path(int x0, int y0, int x1, int y1, int r, int md);
        drain();
        reg_write(REG_START_X, 32'(x0));
        reg_write(REG_START_Y, 32'(y0));
        reg_write(REG_END_X, 32'(x1));
        reg_write(REG_END_Y, 32'(y1));
        reg_write(REG_RADIUS, 32'(r));
        reg_write(REG_MAX_DIST, 32'(md));
    endtask

    function automatic int clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int rand_coord(bit wide);
        if (wide) return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 8192)) - 4096;
    endfunction

    initial begin
        int x0, y0, x1, y1, r, md, t, spread, ox, oy;
        bit wide, busy;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        stall_cycles = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        running = 1'b1;

        // zero-length path from reset values
        send_point(16'd100, 16'd0, 1'b1);

        set_path(0, 0, 2560, 0, 256, 65535);
        send_point(16'd1280, 16'd0, 1'b0);
        send_point(16'd1280, 16'd1000, 1'b0);
        send_point(-16'sd100, 16'd0, 1'b1);
        send_point(16'd5000, 16'd0, 1'b1);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b1);
        send_point(16'd768, 16'd100, 1'b0);
        send_point(16'd512, 16'd0, 1'b0);
        send_point(16'd2600, 16'd0, 1'b1);

        set_path(-32768, -32768, 32767, 32767, 256, 65535);
        send_point(16'd32000, 16'd32000, 1'b1);
        send_point(16'h8000, 16'h8000, 1'b1);

        set_path(32767, -32768, -32768, 32767, 32767, 0);
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'h7fff, 16'h8000, 1'b1);

        set_path(0, 0, 2560, 2560, 512, 100);
        send_point(16'd2000, 16'd2000, 1'b1);
        send_point(16'd50, 16'd0, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            wide = (ph == 2);
            x0 = rand_coord(wide); y0 = rand_coord(wide);
            if (ph == 4) begin
                x1 = x0; y1 = y0;
            end else begin
                x1 = rand_coord(wide); y1 = rand_coord(wide);
            end
            r = (ph == 3) ? 32767 : $urandom_range(0, 1024);
            md = (ph == 5) ? $urandom_range(0, 2000) : 65535;
            set_path(x0, y0, x1, y1, r, md);
            for (int n = 0; n < 160; n++) begin
                busy = (n >= 40 && n < 60);
                if ($urandom_range(0, 4) == 0) begin
                    ox = rand_coord(1); oy = rand_coord(1);
                end else begin
                    t = $urandom_range(0, 1100);
                    spread = r * 2 + 16;
                    ox = clamp16(x0 + longint'(x1 - x0) * t / 1000
                                 + int'($urandom_range(0, 2 * spread)) - spread);
                    oy = clamp16(y0 + longint'(y1 - y0) * t / 1000
                                 + int'($urandom_range(0, 2 * spread)) - spread);
                end
                send_point(16'(ox), 16'(oy), $urandom_range(0, 7) == 0 || n == 159, busy);
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
